/* src/sasmd_pkg.sv */
// Shared constants, operation codes and control types for the signed arithmetic unit.
`default_nettype none
package sasmd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_sts_t;

endpackage
`default_nettype wire

/* src/sasmd_ctrl.sv */
// Sequencer for the arithmetic unit: handshakes and iteration control.
`default_nettype none
module sasmd_ctrl
  import sasmd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_type,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output dp_cmd_t         cmd,
  input  wire dp_sts_t    sts
);

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (req_type inside {OP_MUL, OP_DIV}) begin
            state_next = ST_ITER;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ITER: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* src/sasmd_dp.sv */
// Datapath: operand magnitudes, shift-add multiply, restoring divide, sign fix-up.
`default_nettype none
module sasmd_dp
  import sasmd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [DATA_WIDTH-1:0] operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] operand_b,
  output logic signed [DATA_WIDTH-1:0]      result_value,
  output logic                              divide_by_zero,
  input  wire dp_cmd_t                      cmd,
  output dp_sts_t                           sts
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0]     acc;      // sum, product or partial remainder
  logic [W-1:0]     mq;       // multiplier or dividend/quotient
  logic [W-1:0]     mb;       // shifted multiplicand or divisor
  logic [CNT_W-1:0] cnt;
  op_t              op;
  logic             neg;
  logic             dz;

  logic [W-1:0] a_mag, b_mag;
  logic [W-1:0] div_sh;
  logic [W:0]   div_diff;
  logic [W-1:0] mag_res;
  logic [W-1:0] fixed_res;

  assign a_mag = operand_a[W-1] ? (~operand_a + 1'b1) : operand_a;
  assign b_mag = operand_b[W-1] ? (~operand_b + 1'b1) : operand_b;

  // remainder stays below the divisor, so its top bit is always clear
  assign div_sh   = {acc[W-2:0], mq[W-1]};
  assign div_diff = {1'b0, div_sh} - {1'b0, mb};

  assign sts.last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= op_t'(req_type);
      neg <= operand_a[W-1] ^ operand_b[W-1];
      dz  <= (op_t'(req_type) == OP_DIV) && (operand_b == '0);
      cnt <= CNT_W'(W - 1);
      case (op_t'(req_type))
        OP_ADD: begin
          acc <= operand_a + operand_b;
        end
        OP_SUB: begin
          acc <= operand_a - operand_b;
        end
        OP_MUL: begin
          acc <= '0;
          mq  <= b_mag;
          mb  <= a_mag;
        end
        default: begin
          acc <= '0;
          mq  <= a_mag;
          mb  <= b_mag;
        end
      endcase
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
      if (op == OP_MUL) begin
        if (mq[0]) begin
          acc <= acc + mb;
        end
        mb <= {mb[W-2:0], 1'b0};
        mq <= {1'b0, mq[W-1:1]};
      end else begin
        if (!div_diff[W]) begin
          acc <= div_diff[W-1:0];
          mq  <= {mq[W-2:0], 1'b1};
        end else begin
          acc <= div_sh;
          mq  <= {mq[W-2:0], 1'b0};
        end
      end
    end
  end

  assign mag_res   = (op == OP_MUL) ? acc : mq;
  assign fixed_res = neg ? (~mag_res + 1'b1) : mag_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      divide_by_zero <= 1'b0;
    end else if (cmd.finish) begin
      divide_by_zero <= dz;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (op)
        OP_ADD, OP_SUB: result_value <= acc;
        OP_MUL:         result_value <= fixed_res;
        default:        result_value <= dz ? '0 : fixed_res;
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/signed_add_sub_mul_div_unit.sv */
// Add, subtract, multiply and divide unit: one transaction in, one result out.
// Add/subtract: the sum or difference is loaded on accept and moved to the output register.
// Multiply/divide: load, 32 radix-2 steps of one operand bit each, sign fix-up on the
// output load. No new transaction is taken until the current one has reached the output.
// A new transaction is taken while a result waits; the next result holds until it leaves.
// Synchronous reset returns the sequencer to idle and clears the result valid.
`default_nettype none
module signed_add_sub_mul_div_unit
  import sasmd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [1:0]                   req_type,
  input  wire logic signed [DATA_WIDTH-1:0] operand_a,
  input  wire logic signed [DATA_WIDTH-1:0] operand_b,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic signed [DATA_WIDTH-1:0]      result_value,
  output logic                              divide_by_zero
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sasmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sasmd_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req_type       (req_type),
    .operand_a      (operand_a),
    .operand_b      (operand_b),
    .result_value   (result_value),
    .divide_by_zero (divide_by_zero),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the signed add/subtract/multiply/divide unit, with random stalls.
`default_nettype none
module testbench;
  import sasmd_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  class arith_scoreboard;
    typedef struct {
      op_t          op;
      logic [W-1:0] a;
      logic [W-1:0] b;
      logic [W-1:0] value;
      logic         dz;
    } arith_result_t;

    arith_result_t expected_q[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   op_count[4];
    int unsigned   zero_divides;

    function arith_result_t compute(op_t op, logic [W-1:0] a, logic [W-1:0] b);
      arith_result_t r;
      logic [W-1:0]   mag_a;
      logic [W-1:0]   mag_b;
      logic [W-1:0]   mag;
      logic [2*W-1:0] prod;
      logic           neg;
      r.op    = op;
      r.a     = a;
      r.b     = b;
      r.dz    = 1'b0;
      r.value = '0;
      mag_a   = a[W-1] ? (~a + 1'b1) : a;
      mag_b   = b[W-1] ? (~b + 1'b1) : b;
      neg     = a[W-1] ^ b[W-1];
      case (op)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_MUL: begin
          prod    = mag_a * mag_b;
          mag     = prod[W-1:0];
          r.value = neg ? (~mag + 1'b1) : mag;
        end
        OP_DIV: begin
          if (b == '0) begin
            r.dz = 1'b1;
          end else begin
            mag     = mag_a / mag_b;
            r.value = neg ? (~mag + 1'b1) : mag;
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(op_t op, logic [W-1:0] a, logic [W-1:0] b);
      arith_result_t r;
      r = compute(op, a, b);
      op_count[op]++;
      if (r.dz) zero_divides++;
      expected_q.push_back(r);
    endfunction

    task report(string what, arith_result_t want, logic [W-1:0] got_value, logic got_dz);
      mismatches++;
      $display("mismatch: %s op=%s a=%h b=%h got %h/%b expected %h/%b", what,
               want.op.name(), want.a, want.b, got_value, got_dz, want.value, want.dz);
    endtask

    task check_result(logic [W-1:0] value, logic dz);
      arith_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        want = '{OP_ADD, '0, '0, '0, 1'b0};
        report("result with no pending request", want, value, dz);
      end else begin
        want = expected_q.pop_front();
        if (value !== want.value) report("result_value", want, value, dz);
        if (dz !== want.dz) report("divide_by_zero", want, value, dz);
      end
    endtask

    function int outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [1:0]          req_type  = '0;
  logic signed [W-1:0] operand_a = '0;
  logic signed [W-1:0] operand_b = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic signed [W-1:0] result_value;
  logic                divide_by_zero;

  bit quiet = 1'b0;

  arith_scoreboard sb = new();

  signed_add_sub_mul_div_unit uut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .result_value  (result_value),
    .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(0, 99) < 21);
  end

  // Sample both handshakes with pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall)
        sb.note_request(op_t'(req_type), operand_a, operand_b);
      if (rsp_valid && !rsp_stall)
        sb.check_result(result_value, divide_by_zero);
    end
  end

  task automatic send_op(op_t op, logic [W-1:0] a, logic [W-1:0] b);
    while (!quiet && $urandom_range(0, 99) < 21) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] v;
    int           s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 1;
          2: v = ALL_ONES;
          3: v = MIN_VAL;
          default: v = MAX_VAL;
        endcase
      end
      1, 2: begin
        s = int'($urandom_range(0, 40)) - 20;
        v = s;
      end
      3, 4: begin
        // narrow magnitude, either sign
        v = $urandom;
        v = v & ((W'(1) << $urandom_range(1, W - 1)) - 1'b1);
        if ($urandom_range(0, 1)) v = ~v + 1'b1;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    op_t          op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    int           wait_cycles;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wraparound on add and subtract
    send_op(OP_ADD, MAX_VAL, 1);
    send_op(OP_ADD, MIN_VAL, ALL_ONES);
    send_op(OP_ADD, '0, '0);
    send_op(OP_SUB, MIN_VAL, 1);
    send_op(OP_SUB, MAX_VAL, ALL_ONES);
    send_op(OP_SUB, '0, MIN_VAL);
    // Multiply overflow and most negative operands
    send_op(OP_MUL, MAX_VAL, MAX_VAL);
    send_op(OP_MUL, MIN_VAL, ALL_ONES);
    send_op(OP_MUL, MIN_VAL, MIN_VAL);
    send_op(OP_MUL, ALL_ONES, ALL_ONES);
    send_op(OP_MUL, '0, MIN_VAL);
    send_op(OP_MUL, 12345, -6789);
    // Divide by zero
    send_op(OP_DIV, 7, '0);
    send_op(OP_DIV, MIN_VAL, '0);
    send_op(OP_DIV, '0, '0);
    // Most negative over minus one wraps
    send_op(OP_DIV, MIN_VAL, ALL_ONES);
    send_op(OP_DIV, MIN_VAL, MIN_VAL);
    send_op(OP_DIV, -7, 2);
    send_op(OP_DIV, 7, -2);
    send_op(OP_DIV, 3, MAX_VAL);
    send_op(OP_DIV, MAX_VAL, 1);
    send_op(OP_DIV, MIN_VAL, 1);
    send_op(OP_DIV, ALL_ONES, MIN_VAL);
    send_op(OP_DIV, MAX_VAL, MIN_VAL);

    for (int i = 0; i < 700; i++) begin
      quiet = (i >= 300 && i < 450);
      op = op_t'($urandom_range(0, 3));
      a  = pick_operand();
      b  = pick_operand();
      if (op == OP_DIV && $urandom_range(0, 19) == 0) b = '0;
      send_op(op, a, b);
    end
    req_valid <= 1'b0;
    quiet = 1'b0;

    // Drain, then hold long enough to catch a stray result.
    while (sb.outstanding() != 0) @(posedge clk);
    wait_cycles = 60;
    repeat (wait_cycles) @(posedge clk);

    $display("covered %0d add, %0d sub, %0d mul, %0d div requests (%0d by zero)",
             sb.op_count[OP_ADD], sb.op_count[OP_SUB], sb.op_count[OP_MUL],
             sb.op_count[OP_DIV], sb.zero_divides);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
src/sasmd_pkg.sv
src/sasmd_ctrl.sv
src/sasmd_dp.sv
src/signed_add_sub_mul_div_unit.sv
tb/sv/testbench.sv
